// ===== rtl/saft_pkg.sv =====
// types, constants and helper functions shared by the address frequency table files
package saft_pkg;

  localparam int unsigned ADDR_W     = 40;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned ADDR_BYTES = 5;
  localparam int unsigned THR_W      = 8;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CFG_IDX_W  = 1;

  // packet words that point at preamble or idle noise instead of an address
  localparam logic [15:0] PAT_ALT_LO = 16'h5555;
  localparam logic [15:0] PAT_ALT_HI = 16'hAAAA;
  localparam logic [15:0] PAT_ZEROS  = 16'h0000;
  localparam logic [15:0] PAT_ONES   = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_OBSERVE = 2'd0,
    OP_POP     = 2'd1,
    OP_CONFIRM = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    STAT_COUNTED           = 4'd0,
    STAT_INSERTED          = 4'd1,
    STAT_NO_SIGNAL         = 4'd2,
    STAT_BAD_PATTERN       = 4'd3,
    STAT_ALREADY_CONFIRMED = 4'd4,
    STAT_BELOW_THRESHOLD   = 4'd5,
    STAT_POPPED            = 4'd6,
    STAT_ADDED             = 4'd7,
    STAT_LIST_FULL         = 4'd8,
    STAT_DUPLICATE         = 4'd9,
    STAT_CLEARED           = 4'd10
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REQUIRE_SIGNAL = 1'b0,
    CFG_POP_THRESHOLD  = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONF_SCAN,
    ST_MATCH_SCAN,
    ST_UPDATE,
    ST_TOP_SCAN,
    ST_TOP_READ,
    ST_TOP_WAIT,
    ST_ALT_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    op_e                operation;
    logic [ADDR_W-1:0]  packet_head;
    logic               signal_present;
    logic [ADDR_W-1:0]  confirm_address;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [ADDR_W-1:0]  peak_address;
    logic [COUNT_W-1:0] top_count;
    logic [ADDR_W-1:0]  alternate_address;
    logic               alternate_confirmed;
  } out_item_t;

  function automatic logic word_is_bad(input logic [15:0] w);
    return (w == PAT_ALT_LO) || (w == PAT_ALT_HI) || (w == PAT_ZEROS) || (w == PAT_ONES);
  endfunction

  // packet byte order to address byte order
  function automatic logic [ADDR_W-1:0] reverse_bytes(input logic [ADDR_W-1:0] v);
    logic [ADDR_W-1:0] r;
    r = '0;
    for (int i = 0; i < ADDR_BYTES; i++) begin
      r[8*i +: 8] = v[8*(ADDR_BYTES-1-i) +: 8];
    end
    return r;
  endfunction

endpackage

// ===== rtl/saft_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
module saft_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sniffed_address_frequency_table_unit.sv =====
// top level: sniffed address frequency table with confirmed address list
//
// One transaction at a time runs under a small sequencer that walks the stored
// entries one per cycle through a single shared 40-bit equality compare and a
// single 32-bit magnitude compare. An observe runs a confirmed scan, a match
// scan, a top scan and a top read; a pop runs a top scan, a top read and a scan
// of the confirmed list for the alternate; a confirm runs a confirmed scan; clear
// and a rejected observe go straight to the result, which may wait on the output
// side. The scans are paced by the one read port of each ram. Entries are
// tracked by fill counts, so there is no clearing pass after reset or clear.
// The result sits in an output register, and the input side is ready only while
// the sequencer is idle.
module sniffed_address_frequency_table_unit #(
  parameter int unsigned CANDIDATE_DEPTH = 128,
  parameter int unsigned CONFIRMED_DEPTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [saft_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [saft_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  saft_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output saft_pkg::out_item_t                 out_data_o
);

  import saft_pkg::*;

  localparam int unsigned CAND_AW = $clog2(CANDIDATE_DEPTH);
  localparam int unsigned CAND_CW = $clog2(CANDIDATE_DEPTH + 1);
  localparam int unsigned CONF_AW = (CONFIRMED_DEPTH > 1) ? $clog2(CONFIRMED_DEPTH) : 1;
  localparam int unsigned CONF_CW = $clog2(CONFIRMED_DEPTH + 1);
  localparam int unsigned SCAN_W  = (CAND_CW > CONF_CW) ? CAND_CW : CONF_CW;

  // configuration registers
  logic             require_signal_q;
  logic [THR_W-1:0] pop_threshold_q;

  // sequencer state
  state_e             state_q, state_d;
  op_e                op_q, op_d;
  logic [ADDR_W-1:0]  key_q, key_d;
  logic [SCAN_W-1:0]  scan_cnt_q, scan_cnt_d;
  logic               rd_vld_q, rd_vld_d;
  logic [CAND_AW-1:0] rd_idx_q, rd_idx_d;
  logic [COUNT_W-1:0] best_q, best_d;
  logic [CAND_AW-1:0] best_idx_q, best_idx_d;
  logic               match_q, match_d;
  logic [CAND_AW-1:0] match_idx_q, match_idx_d;
  logic [COUNT_W-1:0] match_cnt_q, match_cnt_d;
  out_item_t          res_q, res_d;

  // table bookkeeping
  logic [CAND_CW-1:0] fill_q, fill_d;
  logic [CAND_AW-1:0] ptr_q, ptr_d;
  logic [CONF_CW-1:0] conf_cnt_q, conf_cnt_d;

  // output register
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  // ram ports
  logic               conf_we;
  logic [CONF_AW-1:0] conf_waddr, conf_raddr;
  logic [ADDR_W-1:0]  conf_rdata;
  logic               cand_we;
  logic [CAND_AW-1:0] cand_waddr, cand_raddr;
  logic [ADDR_W-1:0]  cand_rdata;
  logic               cnt_we;
  logic [CAND_AW-1:0] cnt_waddr;
  logic [COUNT_W-1:0] cnt_wdata, cnt_rdata;

  // shared compare unit
  logic [ADDR_W-1:0]  eq_a;
  logic               eq_hit;
  logic [COUNT_W-1:0] gt_a, gt_b;
  logic               gt;

  logic [SCAN_W-1:0]  scan_limit;
  logic               scan_more;
  logic [THR_W-1:0]   thr_eff;
  logic               on_conf_list;

  saft_ram #(.WIDTH(ADDR_W), .DEPTH(CONFIRMED_DEPTH)) u_conf_ram (
    .clk_i   (clk_i),
    .we_i    (conf_we),
    .waddr_i (conf_waddr),
    .wdata_i (key_q),
    .raddr_i (conf_raddr),
    .rdata_o (conf_rdata)
  );

  saft_ram #(.WIDTH(ADDR_W), .DEPTH(CANDIDATE_DEPTH)) u_cand_ram (
    .clk_i   (clk_i),
    .we_i    (cand_we),
    .waddr_i (cand_waddr),
    .wdata_i (key_q),
    .raddr_i (cand_raddr),
    .rdata_o (cand_rdata)
  );

  saft_ram #(.WIDTH(COUNT_W), .DEPTH(CANDIDATE_DEPTH)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cand_raddr),
    .rdata_o (cnt_rdata)
  );

  // config writes; the host is to write only between transactions, which the block does not enforce
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      require_signal_q <= 1'b1;
      pop_threshold_q  <= THR_W'(2);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_REQUIRE_SIGNAL: require_signal_q <= cfg_data_i[0];
        CFG_POP_THRESHOLD:  pop_threshold_q  <= cfg_data_i[THR_W-1:0];
      endcase
    end
  end

  // zero threshold behaves as one so a zero count never pops
  assign thr_eff = (pop_threshold_q == '0) ? THR_W'(1) : pop_threshold_q;

  assign on_conf_list = (state_q == ST_CONF_SCAN) || (state_q == ST_ALT_SCAN);

  // scan bound: confirmed list or filled candidate slots
  assign scan_limit = on_conf_list ? SCAN_W'(conf_cnt_q) : SCAN_W'(fill_q);
  assign scan_more  = scan_cnt_q < scan_limit;

  // shared equality compare against the key of this transaction
  assign eq_a   = on_conf_list ? conf_rdata : cand_rdata;
  assign eq_hit = rd_vld_q && (eq_a == key_q);

  // shared magnitude compare: top search, or threshold check on the top count
  always_comb begin
    if (state_q == ST_TOP_WAIT) begin
      gt_a = COUNT_W'(thr_eff);
    end else begin
      gt_a = cnt_rdata;
    end
    gt_b = best_q;
  end
  assign gt = gt_a > gt_b;

  assign conf_raddr = scan_cnt_q[CONF_AW-1:0];
  assign conf_waddr = conf_cnt_q[CONF_AW-1:0];
  assign cand_raddr = (state_q == ST_TOP_READ) ? best_idx_q : scan_cnt_q[CAND_AW-1:0];
  assign cand_waddr = ptr_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    scan_cnt_d  = scan_cnt_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = scan_cnt_q[CAND_AW-1:0];
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    match_d     = match_q;
    match_idx_d = match_idx_q;
    match_cnt_d = match_cnt_q;
    res_d       = res_q;
    fill_d      = fill_q;
    ptr_d       = ptr_q;
    conf_cnt_d  = conf_cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    conf_we     = 1'b0;
    cand_we     = 1'b0;
    cnt_we      = 1'b0;
    cnt_waddr   = ptr_q;
    cnt_wdata   = COUNT_W'(1);
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d       = in_data_i.operation;
          scan_cnt_d = '0;
          res_d      = '0;
          best_d     = '0;
          best_idx_d = '0;
          unique case (in_data_i.operation)
            OP_OBSERVE: begin
              key_d = reverse_bytes(in_data_i.packet_head);
              priority if (require_signal_q && !in_data_i.signal_present) begin
                res_d.status = STAT_NO_SIGNAL;
                state_d      = ST_FINISH;
              end else if (word_is_bad(in_data_i.packet_head[15:0]) ||
                           word_is_bad(in_data_i.packet_head[31:16])) begin
                res_d.status = STAT_BAD_PATTERN;
                state_d      = ST_FINISH;
              end else begin
                state_d = ST_CONF_SCAN;
              end
            end
            OP_POP: begin
              if (fill_q == '0) begin
                res_d.status = STAT_BELOW_THRESHOLD;
                state_d      = ST_FINISH;
              end else begin
                state_d = ST_TOP_SCAN;
              end
            end
            OP_CONFIRM: begin
              key_d   = in_data_i.confirm_address;
              state_d = ST_CONF_SCAN;
            end
            OP_CLEAR: begin
              fill_d       = '0;
              ptr_d        = '0;
              conf_cnt_d   = '0;
              res_d.status = STAT_CLEARED;
              state_d      = ST_FINISH;
            end
          endcase
        end
      end

      // look for the key in the confirmed list
      ST_CONF_SCAN: begin
        priority if (eq_hit) begin
          res_d.status = (op_q == OP_OBSERVE) ? STAT_ALREADY_CONFIRMED : STAT_DUPLICATE;
          state_d      = ST_FINISH;
        end else if (!scan_more) begin
          if (op_q == OP_OBSERVE) begin
            scan_cnt_d = '0;
            match_d    = 1'b0;
            state_d    = ST_MATCH_SCAN;
          end else if (conf_cnt_q >= CONF_CW'(CONFIRMED_DEPTH)) begin
            res_d.status = STAT_LIST_FULL;
            state_d      = ST_FINISH;
          end else begin
            conf_we      = 1'b1;
            conf_cnt_d   = conf_cnt_q + CONF_CW'(1);
            res_d.status = STAT_ADDED;
            state_d      = ST_FINISH;
          end
        end else begin
          rd_vld_d   = 1'b1;
          scan_cnt_d = scan_cnt_q + SCAN_W'(1);
        end
      end

      // first candidate slot holding the key
      ST_MATCH_SCAN: begin
        priority if (eq_hit) begin
          match_d     = 1'b1;
          match_idx_d = rd_idx_q;
          match_cnt_d = cnt_rdata;
          state_d     = ST_UPDATE;
        end else if (!scan_more) begin
          state_d = ST_UPDATE;
        end else begin
          rd_vld_d   = 1'b1;
          scan_cnt_d = scan_cnt_q + SCAN_W'(1);
        end
      end

      // count a hit, saturating, or take the ring slot
      ST_UPDATE: begin
        cnt_we = 1'b1;
        if (match_q) begin
          cnt_waddr    = match_idx_q;
          cnt_wdata    = (match_cnt_q == '1) ? match_cnt_q : match_cnt_q + COUNT_W'(1);
          res_d.status = STAT_COUNTED;
        end else begin
          cand_we = 1'b1;
          if (fill_q < CAND_CW'(CANDIDATE_DEPTH)) begin
            fill_d = fill_q + CAND_CW'(1);
          end
          ptr_d        = (ptr_q == CAND_AW'(CANDIDATE_DEPTH - 1)) ? '0 : ptr_q + CAND_AW'(1);
          res_d.status = STAT_INSERTED;
        end
        scan_cnt_d = '0;
        state_d    = ST_TOP_SCAN;
      end

      // first entry with the strictly highest count
      ST_TOP_SCAN: begin
        if (rd_vld_q && gt) begin
          best_d     = cnt_rdata;
          best_idx_d = rd_idx_q;
        end
        if (!scan_more) begin
          state_d = ST_TOP_READ;
        end else begin
          rd_vld_d   = 1'b1;
          scan_cnt_d = scan_cnt_q + SCAN_W'(1);
        end
      end

      ST_TOP_READ: begin
        state_d = ST_TOP_WAIT;
      end

      ST_TOP_WAIT: begin
        res_d.peak_address = cand_rdata;
        res_d.top_count    = best_q;
        if (op_q == OP_OBSERVE) begin
          state_d = ST_FINISH;
        end else if (gt) begin
          // threshold above the top count
          res_d.status = STAT_BELOW_THRESHOLD;
          state_d      = ST_FINISH;
        end else begin
          cnt_we                  = 1'b1;
          cnt_waddr               = best_idx_q;
          cnt_wdata               = '0;
          key_d                   = cand_rdata >> 1;
          res_d.alternate_address = cand_rdata >> 1;
          res_d.status            = STAT_POPPED;
          scan_cnt_d              = '0;
          state_d                 = ST_ALT_SCAN;
        end
      end

      // is the alternate address already confirmed
      ST_ALT_SCAN: begin
        priority if (eq_hit) begin
          res_d.alternate_confirmed = 1'b1;
          state_d                   = ST_FINISH;
        end else if (!scan_more) begin
          state_d = ST_FINISH;
        end else begin
          rd_vld_d   = 1'b1;
          scan_cnt_d = scan_cnt_q + SCAN_W'(1);
        end
      end

      // hand the result over once the output register is free
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_vld_q    <= 1'b0;
      fill_q      <= '0;
      ptr_q       <= '0;
      conf_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_vld_q    <= rd_vld_d;
      fill_q      <= fill_d;
      ptr_q       <= ptr_d;
      conf_cnt_q  <= conf_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    key_q       <= key_d;
    scan_cnt_q  <= scan_cnt_d;
    rd_idx_q    <= rd_idx_d;
    best_q      <= best_d;
    best_idx_q  <= best_idx_d;
    match_q     <= match_d;
    match_idx_q <= match_idx_d;
    match_cnt_q <= match_cnt_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/saft_checker.sv =====
// port-level assertions for the address frequency table, bound to the top level
module saft_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input saft_pkg::out_item_t out_data_o
);

  import saft_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  // one transaction at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a transaction was accepted");

  // alternate fields only carry data for a pop
  a_alt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != STAT_POPPED) |->
      (out_data_o.alternate_address == '0) && !out_data_o.alternate_confirmed)
    else $error("alternate fields set outside a pop");

  // outcomes that never look at the candidate table report no top entry
  a_top_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_data_o.status == STAT_NO_SIGNAL) ||
                    (out_data_o.status == STAT_BAD_PATTERN) ||
                    (out_data_o.status == STAT_ALREADY_CONFIRMED) ||
                    (out_data_o.status == STAT_ADDED) ||
                    (out_data_o.status == STAT_LIST_FULL) ||
                    (out_data_o.status == STAT_DUPLICATE) ||
                    (out_data_o.status == STAT_CLEARED)) |->
      (out_data_o.peak_address == '0) && (out_data_o.top_count == '0))
    else $error("top entry reported for a status without one");

endmodule

bind sniffed_address_frequency_table_unit saft_checker u_saft_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== tb/freq_table_check_pkg.sv =====
`timescale 1ns / 1ps
// scoreboard class and address helpers for the sniffed address frequency table bench
package freq_table_check_pkg;
  import saft_pkg::*;

  localparam int unsigned CAND_SLOTS   = 128;
  localparam int unsigned CONF_SLOTS   = 32;
  localparam int unsigned REPORT_LIMIT = 10;

  // packet byte order to address byte order: packet byte 0 becomes the top byte
  function automatic logic [ADDR_W-1:0] head_to_addr(input logic [ADDR_W-1:0] head);
    return {head[7:0], head[15:8], head[23:16], head[31:24], head[39:32]};
  endfunction

  function automatic bit noise_word(input logic [15:0] w);
    return w inside {PAT_ALT_LO, PAT_ALT_HI, PAT_ZEROS, PAT_ONES};
  endfunction

  class freq_table_shadow;
    logic [ADDR_W-1:0]  cand_addr [CAND_SLOTS];
    logic [COUNT_W-1:0] cand_hits [CAND_SLOTS];
    int unsigned        cand_fill;
    int unsigned        ring_ptr;
    logic [ADDR_W-1:0]  conf_addr [CONF_SLOTS];
    int unsigned        conf_fill;
    bit                 need_signal;
    logic [THR_W-1:0]   pop_min;
    out_item_t          pending_outcomes [$];
    int unsigned        mismatch_count;

    function new();
      cand_fill      = 0;
      ring_ptr       = 0;
      conf_fill      = 0;
      need_signal    = 1'b1;
      pop_min        = 8'd2;
      mismatch_count = 0;
    endfunction

    function void write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_REQUIRE_SIGNAL: need_signal = value[0];
        CFG_POP_THRESHOLD:  pop_min = value[THR_W-1:0];
        default: ;
      endcase
    endfunction

    function bit is_listed(input logic [ADDR_W-1:0] addr);
      int unsigned i;
      for (i = 0; i < conf_fill; i++) begin
        if (conf_addr[i] == addr) return 1'b1;
      end
      return 1'b0;
    endfunction

    // first slot with the strictly highest count, slot 0 when all are zero
    function int unsigned best_slot();
      int unsigned i;
      int unsigned idx;
      logic [COUNT_W-1:0] best;
      idx  = 0;
      best = '0;
      for (i = 0; i < cand_fill; i++) begin
        if (cand_hits[i] > best) begin
          best = cand_hits[i];
          idx  = i;
        end
      end
      return idx;
    endfunction

    // accepted input transaction: update the shadow tables and queue its outcome
    function void note_item(input in_item_t item);
      out_item_t          res;
      logic [ADDR_W-1:0]  addr;
      logic [COUNT_W-1:0] floor_cnt;
      int unsigned        i;
      int unsigned        t;
      bit                 found;
      res = '0;
      case (item.operation)
        OP_OBSERVE: begin
          addr = head_to_addr(item.packet_head);
          if (need_signal && !item.signal_present) begin
            res.status = STAT_NO_SIGNAL;
          end else if (noise_word(item.packet_head[15:0]) ||
                       noise_word(item.packet_head[31:16])) begin
            res.status = STAT_BAD_PATTERN;
          end else if (is_listed(addr)) begin
            res.status = STAT_ALREADY_CONFIRMED;
          end else begin
            found = 1'b0;
            for (i = 0; i < cand_fill && !found; i++) begin
              if (cand_addr[i] == addr) begin
                found = 1'b1;
                if (cand_hits[i] != '1) cand_hits[i] = cand_hits[i] + 1'b1;
              end
            end
            if (found) begin
              res.status = STAT_COUNTED;
            end else begin
              cand_addr[ring_ptr] = addr;
              cand_hits[ring_ptr] = 1;
              if (cand_fill < CAND_SLOTS) cand_fill++;
              ring_ptr   = (ring_ptr + 1) % CAND_SLOTS;
              res.status = STAT_INSERTED;
            end
            t = best_slot();
            res.peak_address = cand_addr[t];
            res.top_count    = cand_hits[t];
          end
        end
        OP_POP: begin
          floor_cnt = (pop_min == 0) ? 1 : COUNT_W'(pop_min);
          t = best_slot();
          if (cand_fill == 0) begin
            res.status = STAT_BELOW_THRESHOLD;
          end else begin
            res.peak_address = cand_addr[t];
            res.top_count    = cand_hits[t];
            if (cand_hits[t] < floor_cnt) begin
              res.status = STAT_BELOW_THRESHOLD;
            end else begin
              res.status              = STAT_POPPED;
              cand_hits[t]            = '0;
              res.alternate_address   = cand_addr[t] >> 1;
              res.alternate_confirmed = is_listed(res.alternate_address);
            end
          end
        end
        OP_CONFIRM: begin
          if (is_listed(item.confirm_address)) begin
            res.status = STAT_DUPLICATE;
          end else if (conf_fill >= CONF_SLOTS) begin
            res.status = STAT_LIST_FULL;
          end else begin
            conf_addr[conf_fill] = item.confirm_address;
            conf_fill++;
            res.status = STAT_ADDED;
          end
        end
        default: begin
          cand_fill  = 0;
          ring_ptr   = 0;
          conf_fill  = 0;
          res.status = STAT_CLEARED;
        end
      endcase
      pending_outcomes.push_back(res);
    endfunction

    function void check_result(input out_item_t got);
      out_item_t want;
      bit        bad;
      if (pending_outcomes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("[%0t] unexpected result, status %0d top %h", $time, got.status,
                   got.peak_address);
        return;
      end
      want = pending_outcomes.pop_front();
      bad  = (got.status !== want.status) ||
             (got.peak_address !== want.peak_address) ||
             (got.top_count !== want.top_count) ||
             (got.alternate_address !== want.alternate_address) ||
             (got.alternate_confirmed !== want.alternate_confirmed);
      if (bad) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("[%0t] mismatch: status %0d/%0d top %h/%h count %0d/%0d alt %h/%h conf %b/%b",
                   $time, want.status, got.status, want.peak_address, got.peak_address,
                   want.top_count, got.top_count, want.alternate_address,
                   got.alternate_address, want.alternate_confirmed, got.alternate_confirmed);
      end
    endfunction
  endclass

endpackage

// ===== tb/sniffed_address_frequency_table_unit_tb.sv =====
`timescale 1ns / 1ps
// top-level bench for sniffed_address_frequency_table_unit with random and directed traffic
module sniffed_address_frequency_table_unit_tb;
  import saft_pkg::*;
  import freq_table_check_pkg::*;

  // traffic mix of one phase: operation weights, address sources and idling
  typedef struct {
    int unsigned obs;
    int unsigned pop;
    int unsigned conf;
    int unsigned clr;
    int unsigned pool_n;     // how many of the known heads are in play
    int unsigned fresh_pct;  // observes with a never-seen clean head
    int unsigned noise_pct;  // observes carrying a preamble or idle word
    int unsigned nosig_pct;  // observes without the power detector flag
    int unsigned gap_max;    // longest sender gap between bursts, 0 for none
  } mix_t;

  localparam int unsigned POOL_SIZE = 8;
  localparam int unsigned LONG_HOLD = 2500;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;

  freq_table_shadow      table_shadow = new();
  logic [ADDR_W-1:0]     head_pool [POOL_SIZE];
  bit                    long_hold_req = 1'b0;

  sniffed_address_frequency_table_unit #(
    .CANDIDATE_DEPTH(CAND_SLOTS),
    .CONFIRMED_DEPTH(CONF_SLOTS)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [ADDR_W-1:0] rand40();
    logic [ADDR_W-1:0] v;
    v[31:0]  = $urandom();
    v[39:32] = 8'($urandom());
    return v;
  endfunction

  // a head that passes the pattern filter
  function automatic logic [ADDR_W-1:0] clean_head();
    logic [ADDR_W-1:0] h;
    do begin
      h = rand40();
    end while (noise_word(h[15:0]) || noise_word(h[31:16]));
    return h;
  endfunction

  // plant one of the four rejected words in either checked half
  function automatic logic [ADDR_W-1:0] noisy_head(input logic [ADDR_W-1:0] h);
    logic [15:0] pat;
    case ($urandom_range(3, 0))
      0:       pat = PAT_ALT_LO;
      1:       pat = PAT_ALT_HI;
      2:       pat = PAT_ZEROS;
      default: pat = PAT_ONES;
    endcase
    if ($urandom_range(1, 0) == 1) h[15:0] = pat;
    else h[31:16] = pat;
    return h;
  endfunction

  // unused fields of every transaction carry random bits
  function automatic in_item_t base_item(input op_e op);
    in_item_t it;
    it.operation       = op;
    it.packet_head     = rand40();
    it.signal_present  = 1'($urandom());
    it.confirm_address = rand40();
    return it;
  endfunction

  function automatic in_item_t observe_item(input logic [ADDR_W-1:0] head, input logic sig);
    in_item_t it;
    it                = base_item(OP_OBSERVE);
    it.packet_head    = head;
    it.signal_present = sig;
    return it;
  endfunction

  function automatic in_item_t confirm_item(input logic [ADDR_W-1:0] addr);
    in_item_t it;
    it                 = base_item(OP_CONFIRM);
    it.confirm_address = addr;
    return it;
  endfunction

  function automatic in_item_t build_item(input mix_t m);
    in_item_t    it;
    int unsigned roll;
    int unsigned k;
    roll = $urandom_range(m.obs + m.pop + m.conf + m.clr - 1, 0);
    if (roll < m.obs) it = base_item(OP_OBSERVE);
    else if (roll < m.obs + m.pop) it = base_item(OP_POP);
    else if (roll < m.obs + m.pop + m.conf) it = base_item(OP_CONFIRM);
    else it = base_item(OP_CLEAR);
    k = $urandom_range(m.pool_n - 1, 0);
    case (it.operation)
      OP_OBSERVE: begin
        it.signal_present = ($urandom_range(99, 0) >= m.nosig_pct);
        roll = $urandom_range(99, 0);
        if (roll < m.noise_pct) it.packet_head = noisy_head(it.packet_head);
        else if (roll < m.noise_pct + m.fresh_pct) it.packet_head = clean_head();
        else it.packet_head = head_pool[k];
      end
      OP_CONFIRM: begin
        // known addresses block later observes, shifted ones mark alternates
        case ($urandom_range(4, 0))
          0:       it.confirm_address = head_to_addr(head_pool[k]);
          1:       it.confirm_address = head_to_addr(head_pool[k]) >> 1;
          default: ;
        endcase
      end
      default: ;
    endcase
    return it;
  endfunction

  // called at a rising edge; valid stays up on return so bursts run back to back
  task automatic offer_item(input in_item_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    do begin
      @(posedge clk);
    end while (!in_ready);
    table_shadow.note_item(item);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    table_shadow.write_reg(idx, value);
  endtask

  // sender pause until the block has handed back every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (table_shadow.pending_outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_regs(input bit need_sig, input logic [THR_W-1:0] thr);
    // upper data bits of the one-bit register are don't-care
    write_reg(CFG_REQUIRE_SIGNAL, {7'($urandom()), need_sig});
    write_reg(CFG_POP_THRESHOLD, thr);
  endtask

  task automatic run_stream(input int unsigned count, input mix_t m);
    int unsigned burst;
    int unsigned gap;
    burst = 0;
    repeat (count) begin
      if (burst == 0) begin
        gap = (m.gap_max == 0) ? 0 : $urandom_range(m.gap_max, 0);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = $urandom_range(16, 1);
      end
      offer_item(build_item(m));
      burst--;
    end
  endtask

  // directed opening with reset register values (signal required, threshold 2)
  task automatic run_directed();
    logic [ADDR_W-1:0] a0;
    logic [ADDR_W-1:0] a1;
    a0 = head_to_addr(head_pool[0]);
    a1 = head_to_addr(head_pool[1]);
    offer_item(base_item(OP_POP));                        // pop on an empty table
    offer_item(observe_item(head_pool[0], 1'b0));         // no detector flag
    offer_item(observe_item({rand40()} & 40'hFF_FFFF_0000 | 40'h5555, 1'b1));
    offer_item(observe_item({rand40()} & 40'hFF_0000_FFFF | 40'hAAAA_0000, 1'b1));
    offer_item(observe_item(40'h00_0000_0000, 1'b1));
    offer_item(observe_item(40'hFF_FFFF_FFFF, 1'b1));
    offer_item(observe_item(40'hFF_0001_FFFE, 1'b1));     // extreme bytes, clean words
    offer_item(observe_item(40'h00_FFFE_0001, 1'b1));
    offer_item(base_item(OP_CLEAR));
    offer_item(observe_item(head_pool[0], 1'b1));         // insert
    offer_item(observe_item(head_pool[0], 1'b1));         // count
    offer_item(observe_item(head_pool[1], 1'b1));
    offer_item(base_item(OP_POP));                        // pops the first address
    offer_item(base_item(OP_POP));                        // second one still at one hit
    offer_item(confirm_item(a1));
    offer_item(confirm_item(a1));                         // duplicate dropped
    offer_item(observe_item(head_pool[1], 1'b1));         // now already confirmed
    offer_item(confirm_item(a0 >> 1));                    // alternate of the first
    offer_item(observe_item(head_pool[0], 1'b1));         // tie at one hit, first slot wins
    offer_item(observe_item(head_pool[0], 1'b1));
    offer_item(base_item(OP_POP));                        // pop with alternate confirmed
    offer_item(confirm_item('0));
    offer_item(confirm_item('1));
    offer_item(base_item(OP_CLEAR));
    offer_item(base_item(OP_POP));                        // empty again after clear
  endtask

  // result side: check on every handshake, stall on a shifting pattern, and
  // honor one long hold-off while the sender keeps pushing
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned mode_left;
    int unsigned stall_pct;
    hold_left = 0;
    mode_left = 0;
    stall_pct = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) table_shadow.check_result(out_data);
      if (long_hold_req) begin
        hold_left     = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(200, 10);
        case ($urandom_range(3, 0))
          0:       stall_pct = 0;
          1:       stall_pct = 30;
          2:       stall_pct = 70;
          default: stall_pct = 95;
        endcase
      end
      mode_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99, 0) >= stall_pct);
      end
    end
  end

  // worst correct run is near 900 transactions
  initial begin : watchdog
    #20_000_000;
    $display("sniffed_address_frequency_table_unit regression: fail");
    $finish;
  end

  initial begin : stimulus
    int unsigned i;
    rst_n    <= 1'b0;
    cfg_we   <= 1'b0;
    cfg_idx  <= CFG_REQUIRE_SIGNAL;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_data  <= '0;
    for (i = 0; i < POOL_SIZE; i++) head_pool[i] = clean_head();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    drain_results();

    // mixed traffic at the reset settings; the receiver holds off early on so
    // the output register fills and the input side backs up
    set_regs(1'b1, 8'd2);
    long_hold_req = 1'b1;
    run_stream(180, '{60, 20, 15, 5, 6, 10, 10, 10, 12});
    drain_results();

    // one address hammered up to the top threshold, sender never idles
    set_regs(1'b0, 8'd255);
    offer_item(base_item(OP_CLEAR));
    run_stream(300, '{97, 3, 0, 0, 1, 0, 0, 20, 0});
    offer_item(base_item(OP_POP));
    drain_results();

    // no clears: fresh addresses wrap the candidate ring and fill the list;
    // a zero threshold behaves as one
    set_regs(1'b0, 8'd0);
    offer_item(base_item(OP_CLEAR));
    run_stream(260, '{70, 10, 20, 0, 4, 80, 5, 5, 6});
    drain_results();

    // lowest legal threshold with the signal check back on
    set_regs(1'b1, 8'd1);
    run_stream(150, '{55, 25, 15, 5, 8, 15, 10, 10, 15});
    drain_results();

    repeat (400) @(posedge clk);
    if (table_shadow.mismatch_count == 0 && table_shadow.pending_outcomes.size() == 0) begin
      $display("sniffed_address_frequency_table_unit regression: pass");
    end else begin
      $display("sniffed_address_frequency_table_unit regression: fail");
    end
    $finish;
  end

endmodule
